/* rtl/mma_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers for the matrix multiply-accumulate block.
// Used by the channel interfaces, the multiply-accumulate unit and the top level.
package mma_pkg;

	localparam int MAX_DIM    = 8;
	localparam int ELEM_WIDTH = 16;

	localparam int CFG_W   = 4;
	localparam int FIELD_W = 3;
	localparam int MODE_W  = 2;
	localparam int SUM_W   = 40;
	localparam int PROD_W  = 2 * ELEM_WIDTH;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DCNT_W  = $clog2(MAX_DIM) + 1;
	localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int CFG_IDX_W = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIMENSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_OF_B    = 2'd2;

	localparam logic [CFG_W-1:0] CFG_RESET_DIM = 4'd8;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} term_t;

	function automatic logic [DCNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
		logic [DCNT_W-1:0] r;
		if (d == '0) begin
			r = DCNT_W'(1);
		end else if (int'(d) > MAX_DIM) begin
			r = DCNT_W'(MAX_DIM);
		end else begin
			r = DCNT_W'(d);
		end
		return r;
	endfunction

endpackage

/* rtl/mma_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on mma_pkg for the field widths.
interface mma_item_if;
	logic                                       valid;
	logic                                       ready;
	logic [mma_pkg::MODE_W-1:0]                 mode;
	logic [mma_pkg::FIELD_W-1:0]                elem_row;
	logic [mma_pkg::FIELD_W-1:0]                elem_col;
	logic signed [mma_pkg::ELEM_WIDTH-1:0]      elem_value;

	modport source(output valid, mode, elem_row, elem_col, elem_value, input ready);
	modport sink(input valid, mode, elem_row, elem_col, elem_value, output ready);
endinterface

interface mma_result_if;
	logic                                       valid;
	logic                                       ready;
	logic [mma_pkg::FIELD_W-1:0]                out_row;
	logic [mma_pkg::FIELD_W-1:0]                out_col;
	logic signed [mma_pkg::SUM_W-1:0]           out_value;
	logic                                       last;

	modport source(output valid, out_row, out_col, out_value, last, input ready);
	modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface

/* rtl/mma_mac.sv */
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: a registered multiplier followed by a 40-bit accumulator.
// Depends on mma_pkg for widths and the term control struct.
module mma_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [mma_pkg::ELEM_WIDTH-1:0] a,
	input  logic signed [mma_pkg::ELEM_WIDTH-1:0] b,
	input  mma_pkg::term_t                        term,
	output logic signed [mma_pkg::SUM_W-1:0]      acc,
	output logic                                  done
);

	logic signed [mma_pkg::PROD_W-1:0] prod_s2;
	mma_pkg::term_t                    term_s2;
	logic signed [mma_pkg::SUM_W-1:0]  acc_q;
	logic                              done_q;

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			term_s2 <= term;
			done_q  <= term_s2.valid && term_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (term_s2.valid) begin
			acc_q <= (term_s2.first ? '0 : acc_q) + mma_pkg::SUM_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

/* rtl/matrix_multiply_accumulate.sv */
`timescale 1ns / 1ps
// Top level of the matrix multiply-accumulate block: element stores, sequencer and result register.
// Depends on mma_pkg, the channel interfaces in mma_ifs.sv and the mma_mac unit.
//
//   channel  direction  carries
//   item     in         mode, elem_row, elem_col, elem_value
//   result   out        out_row, out_col, out_value, last
//   cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// A load request is taken without leaving the idle state. In a compute request each
// product element issues n store reads, one per cycle, through the single multiplier and
// accumulator, then waits for the pipeline to drain before it is emitted.
// Reset clears the sequencer, the dimension registers (to 8) and the result valid flag;
// the element stores hold undefined values until written.
// A stalled result holds the sequencer at the emit step; the item channel is ready only when idle.
module matrix_multiply_accumulate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mma_pkg::CFG_W-1:0]         cfg_data,
	mma_item_if.sink                          item,
	mma_result_if.source                      result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                          state_q;
	logic [mma_pkg::CFG_W-1:0]           rows_q;
	logic [mma_pkg::CFG_W-1:0]           inner_q;
	logic [mma_pkg::CFG_W-1:0]           cols_q;
	logic [mma_pkg::DCNT_W-1:0]          m_dim;
	logic [mma_pkg::DCNT_W-1:0]          n_dim;
	logic [mma_pkg::DCNT_W-1:0]          l_dim;
	logic [mma_pkg::CNT_W-1:0]           i_q;
	logic [mma_pkg::CNT_W-1:0]           j_q;
	logic [mma_pkg::CNT_W-1:0]           k_q;
	logic                                i_last;
	logic                                j_last;
	logic                                k_last;
	logic                                item_acc;
	logic                                issue;
	logic                                out_free;
	logic                                emit_load;
	logic                                a_we;
	logic                                b_we;
	logic [mma_pkg::ADDR_W-1:0]          wr_addr;
	logic [mma_pkg::ADDR_W-1:0]          a_rd_addr;
	logic [mma_pkg::ADDR_W-1:0]          b_rd_addr;
	logic signed [mma_pkg::ELEM_WIDTH-1:0] store_a [mma_pkg::DEPTH];
	logic signed [mma_pkg::ELEM_WIDTH-1:0] store_b [mma_pkg::DEPTH];
	logic signed [mma_pkg::ELEM_WIDTH-1:0] rd_a_s1;
	logic signed [mma_pkg::ELEM_WIDTH-1:0] rd_b_s1;
	mma_pkg::term_t                      term_s1;
	logic signed [mma_pkg::SUM_W-1:0]    mac_acc;
	logic                                mac_done;
	logic                                res_valid_q;
	logic [mma_pkg::FIELD_W-1:0]         res_row_q;
	logic [mma_pkg::FIELD_W-1:0]         res_col_q;
	logic signed [mma_pkg::SUM_W-1:0]    res_value_q;
	logic                                res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= mma_pkg::CFG_RESET_DIM;
			inner_q <= mma_pkg::CFG_RESET_DIM;
			cols_q  <= mma_pkg::CFG_RESET_DIM;
		end else if (cfg_we) begin
			case (cfg_index)
				mma_pkg::CFG_ROWS_OF_A:       rows_q  <= cfg_data;
				mma_pkg::CFG_INNER_DIMENSION: inner_q <= cfg_data;
				mma_pkg::CFG_COLUMNS_OF_B:    cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m_dim = mma_pkg::clamp_dim(rows_q);
	assign n_dim = mma_pkg::clamp_dim(inner_q);
	assign l_dim = mma_pkg::clamp_dim(cols_q);

	assign i_last = (mma_pkg::DCNT_W'(i_q) + mma_pkg::DCNT_W'(1)) == m_dim;
	assign j_last = (mma_pkg::DCNT_W'(j_q) + mma_pkg::DCNT_W'(1)) == l_dim;
	assign k_last = (mma_pkg::DCNT_W'(k_q) + mma_pkg::DCNT_W'(1)) == n_dim;

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign issue      = (state_q == ST_READ);
	assign out_free   = !res_valid_q || result.ready;
	assign emit_load  = (state_q == ST_EMIT) && out_free;

	// Loads outside the configured shape of the target matrix are dropped.
	assign a_we = item_acc && (item.mode == mma_pkg::MODE_LOAD_A)
		&& (int'(item.elem_row) < int'(m_dim)) && (int'(item.elem_col) < int'(n_dim));
	assign b_we = item_acc && (item.mode == mma_pkg::MODE_LOAD_B)
		&& (int'(item.elem_row) < int'(n_dim)) && (int'(item.elem_col) < int'(l_dim));

	assign wr_addr   = mma_pkg::ADDR_W'(int'(item.elem_row) * mma_pkg::MAX_DIM
		+ int'(item.elem_col));
	assign a_rd_addr = mma_pkg::ADDR_W'(int'(i_q) * mma_pkg::MAX_DIM + int'(k_q));
	assign b_rd_addr = mma_pkg::ADDR_W'(int'(k_q) * mma_pkg::MAX_DIM + int'(j_q));

	always_ff @(posedge clk) begin
		if (a_we) begin
			store_a[wr_addr] <= item.elem_value;
		end
		if (b_we) begin
			store_b[wr_addr] <= item.elem_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= store_a[a_rd_addr];
		rd_b_s1 <= store_b[b_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s1 <= '0;
		end else begin
			term_s1.valid <= issue;
			term_s1.first <= (k_q == '0);
			term_s1.last  <= k_last;
		end
	end

	mma_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (rd_a_s1),
		.b      (rd_b_s1),
		.term   (term_s1),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc && item.mode == mma_pkg::MODE_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + mma_pkg::CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + mma_pkg::CNT_W'(1);
								state_q <= ST_READ;
							end
						end else begin
							j_q     <= j_q + mma_pkg::CNT_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_row_q   <= mma_pkg::FIELD_W'(i_q);
			res_col_q   <= mma_pkg::FIELD_W'(j_q);
			res_value_q <= mac_acc;
			res_last_q  <= i_last && j_last;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.out_row   = res_row_q;
	assign result.out_col   = res_col_q;
	assign result.out_value = res_value_q;
	assign result.last      = res_last_q;

	// The accumulator finishes an element only while the sequencer waits for it.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("accumulator finished an element outside the drain step");

	// No product term may still be in flight when an element is emitted.
	a_emit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !term_s1.valid && !mac_done)
		else $error("product term in flight while emitting");

	// A new element only starts reading once the previous one has been handed over.
	a_read_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && !(i_last && j_last) |=> state_q == ST_READ && k_q == '0)
		else $error("sequencer did not restart the inner loop after emitting");

endmodule

/* bench/matrix_multiply_accumulate_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the matrix multiply-accumulate block: element loads and product requests
// go in through the item channel and every product element is checked against a local predictor.
// Depends on mma_pkg, the channel interfaces in mma_ifs.sv and the matrix_multiply_accumulate top.
module matrix_multiply_accumulate_tb;
	import mma_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = 16'sh8000;
	localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = 16'sh7fff;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [MODE_W-1:0]            mode;
		logic [FIELD_W-1:0]           row;
		logic [FIELD_W-1:0]           col;
		logic signed [ELEM_WIDTH-1:0] value;
	} request_t;

	typedef struct {
		logic [FIELD_W-1:0]      row;
		logic [FIELD_W-1:0]      col;
		logic signed [SUM_W-1:0] value;
		logic                    last;
	} product_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	mma_item_if   item_ch();
	mma_result_if result_ch();

	matrix_multiply_accumulate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch.sink),
		.result    (result_ch.source)
	);

	request_t pending_requests[$];
	product_t expected_products[$];

	logic signed [ELEM_WIDTH-1:0] mat_a [DEPTH];
	logic signed [ELEM_WIDTH-1:0] mat_b [DEPTH];
	bit a_written [DEPTH];
	bit b_written [DEPTH];
	logic [CFG_W-1:0] dim_rows = CFG_RESET_DIM;
	logic [CFG_W-1:0] dim_inner = CFG_RESET_DIM;
	logic [CFG_W-1:0] dim_cols = CFG_RESET_DIM;

	int sender_idle_pct = 36;
	int receiver_idle_pct = 67;
	int fault_count = 0;
	int queued_items = 0;

	function automatic int effective_dim(input logic [CFG_W-1:0] d);
		if (d == '0) begin
			return 1;
		end
		if (int'(d) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(d);
	endfunction

	task automatic predict_products(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] row,
			input logic [FIELD_W-1:0] col, input logic signed [ELEM_WIDTH-1:0] value);
		int m;
		int n;
		int l;
		logic signed [PROD_W-1:0] term;
		logic signed [SUM_W-1:0] acc;
		product_t p;
		m = effective_dim(dim_rows);
		n = effective_dim(dim_inner);
		l = effective_dim(dim_cols);
		case (mode)
			MODE_LOAD_A: begin
				if (int'(row) < m && int'(col) < n) begin
					mat_a[int'(row) * MAX_DIM + int'(col)] = value;
				end
			end
			MODE_LOAD_B: begin
				if (int'(row) < n && int'(col) < l) begin
					mat_b[int'(row) * MAX_DIM + int'(col)] = value;
				end
			end
			MODE_COMPUTE: begin
				for (int i = 0; i < m; i++) begin
					for (int j = 0; j < l; j++) begin
						acc = '0;
						for (int k = 0; k < n; k++) begin
							term = mat_a[i * MAX_DIM + k] * mat_b[k * MAX_DIM + j];
							acc = acc + term;
						end
						p.row = FIELD_W'(i);
						p.col = FIELD_W'(j);
						p.value = acc;
						p.last = (i == m - 1 && j == l - 1);
						expected_products.push_back(p);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin : driver
		request_t req;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				predict_products(item_ch.mode, item_ch.elem_row, item_ch.elem_col, item_ch.elem_value);
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					req = pending_requests.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.mode <= req.mode;
					item_ch.elem_row <= req.row;
					item_ch.elem_col <= req.col;
					item_ch.elem_value <= req.value;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t %s: got (%0d,%0d) value %0d last %0b", $realtime, what,
				result_ch.out_row, result_ch.out_col, result_ch.out_value, result_ch.last);
		end
	endtask

	always @(posedge clk) begin : monitor
		product_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_products.size() == 0) begin
					report_fault("unexpected product element");
				end else begin
					want = expected_products.pop_front();
					if (result_ch.out_row !== want.row || result_ch.out_col !== want.col
							|| result_ch.out_value !== want.value || result_ch.last !== want.last) begin
						report_fault($sformatf("product mismatch, expected (%0d,%0d) value %0d last %0b",
							want.row, want.col, want.value, want.last));
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] row,
			input logic [FIELD_W-1:0] col, input logic signed [ELEM_WIDTH-1:0] value);
		request_t req;
		req.mode = mode;
		req.row = row;
		req.col = col;
		req.value = value;
		pending_requests.push_back(req);
		queued_items++;
		if (mode == MODE_LOAD_A && int'(row) < effective_dim(dim_rows)
				&& int'(col) < effective_dim(dim_inner)) begin
			a_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
		end
		if (mode == MODE_LOAD_B && int'(row) < effective_dim(dim_inner)
				&& int'(col) < effective_dim(dim_cols)) begin
			b_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
		end
	endtask

	task automatic queue_random_load(input bit in_range);
		logic [MODE_W-1:0] mode;
		int row_lim;
		int col_lim;
		mode = $urandom_range(1) ? MODE_LOAD_B : MODE_LOAD_A;
		row_lim = (mode == MODE_LOAD_A) ? effective_dim(dim_rows) : effective_dim(dim_inner);
		col_lim = (mode == MODE_LOAD_A) ? effective_dim(dim_inner) : effective_dim(dim_cols);
		if (in_range) begin
			queue_request(mode, FIELD_W'($urandom_range(row_lim - 1)),
				FIELD_W'($urandom_range(col_lim - 1)), ELEM_WIDTH'($urandom));
		end else begin
			queue_request(mode, FIELD_W'($urandom), FIELD_W'($urandom), ELEM_WIDTH'($urandom));
		end
	endtask

	task automatic queue_product();
		int m;
		int n;
		int l;
		m = effective_dim(dim_rows);
		n = effective_dim(dim_inner);
		l = effective_dim(dim_cols);
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < m; i++) begin
				if (!a_written[i * MAX_DIM + k]) begin
					queue_request(MODE_LOAD_A, FIELD_W'(i), FIELD_W'(k), ELEM_WIDTH'($urandom));
				end
			end
			for (int j = 0; j < l; j++) begin
				if (!b_written[k * MAX_DIM + j]) begin
					queue_request(MODE_LOAD_B, FIELD_W'(k), FIELD_W'(j), ELEM_WIDTH'($urandom));
				end
			end
		end
		queue_request(MODE_COMPUTE, FIELD_W'($urandom), FIELD_W'($urandom), ELEM_WIDTH'($urandom));
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || item_ch.valid || expected_products.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_config(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
	endtask

	task automatic set_dimensions(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
			input logic [CFG_W-1:0] cols);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_config(CFG_ROWS_OF_A, rows);
		write_config(CFG_INNER_DIMENSION, inner);
		write_config(CFG_COLUMNS_OF_B, cols);
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_rows = rows;
		dim_inner = inner;
		dim_cols = cols;
	endtask

	function automatic logic [CFG_W-1:0] choose_dim();
		case ($urandom_range(9))
			6: return CFG_W'(1);
			7: return CFG_W'(MAX_DIM);
			8: return CFG_W'($urandom_range(5, 7));
			9: return $urandom_range(1) ? CFG_W'(0) : CFG_W'($urandom_range(9, 15));
			default: return CFG_W'($urandom_range(1, 4));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_LOAD_A;
		item_ch.elem_row = '0;
		item_ch.elem_col = '0;
		item_ch.elem_value = '0;
		result_ch.ready = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("[matrix_multiply_accumulate] ERROR");
		$finish;
	end

	initial begin : stimulus
		int r;
		bit first_phase;
		first_phase = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_dimensions(4'd1, 4'd1, 4'd1);
		queue_request(MODE_LOAD_A, 3'd0, 3'd0, ELEM_MIN);
		queue_request(MODE_LOAD_B, 3'd0, 3'd0, ELEM_MIN);
		queue_request(MODE_COMPUTE, 3'd0, 3'd0, '0);
		queue_request(MODE_LOAD_A, 3'd0, 3'd0, ELEM_MAX);
		queue_request(MODE_COMPUTE, 3'd7, 3'd7, ELEM_MIN);
		queue_request(MODE_LOAD_B, 3'd0, 3'd0, ELEM_MAX);
		queue_request(MODE_LOAD_A, 3'd1, 3'd0, 16'sh1234);
		queue_request(MODE_LOAD_A, 3'd0, 3'd1, 16'sh4321);
		queue_request(MODE_LOAD_B, 3'd1, 3'd0, -16'sd1);
		queue_request(MODE_LOAD_B, 3'd7, 3'd7, 16'sh5a5a);
		queue_request(MODE_UNUSED, 3'd7, 3'd7, -16'sd1);
		queue_request(MODE_COMPUTE, 3'd0, 3'd0, '0);

		set_dimensions(4'd0, 4'd15, 4'd0);
		for (int k = 0; k < MAX_DIM; k++) begin
			queue_request(MODE_LOAD_A, 3'd0, FIELD_W'(k), ELEM_MIN);
			queue_request(MODE_LOAD_B, FIELD_W'(k), 3'd0, ELEM_MIN);
		end
		queue_request(MODE_COMPUTE, 3'd0, 3'd0, '0);

		while (queued_items < 100) begin
			if (queued_items >= 67) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end else if (queued_items >= 34) begin
				sender_idle_pct = 67;
				receiver_idle_pct = 36;
			end
			set_dimensions(choose_dim(), choose_dim(), choose_dim());
			repeat ($urandom_range(4, 14)) begin
				r = $urandom_range(99);
				if (r < 75) begin
					queue_random_load(1'b1);
				end else if (r < 85) begin
					queue_random_load(1'b0);
				end else if (r < 90) begin
					queue_request(MODE_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom),
						ELEM_WIDTH'($urandom));
				end else begin
					queue_product();
				end
			end
			if (first_phase) begin
				queue_product();
				drain();
				first_phase = 1'b0;
			end
			queue_product();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && expected_products.size() == 0) begin
			$display("[matrix_multiply_accumulate] OK");
		end else begin
			$display("[matrix_multiply_accumulate] ERROR");
		end
		$finish;
	end

endmodule
